@@ rtl/core/rhdf_pkg.sv @@
// Shared types, constants and hash helpers for the record hash dedup filter.
// No dependencies; every rtl/core file refers to it by scoped names.
`timescale 1ns / 1ps

package rhdf_pkg;

  localparam int TABLE_DEPTH_DEF  = 8192;
  localparam int MAX_ELEMENTS_DEF = 512;

  localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;

  // Item kinds
  localparam logic ACT_NAME   = 1'b0;
  localparam logic ACT_VECTOR = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_NEW      = 2'd0;
  localparam logic [1:0] STATUS_DUP      = 2'd1;
  localparam logic [1:0] STATUS_DISABLED = 2'd2;
  localparam logic [1:0] STATUS_REJECT   = 2'd3;

  // Configuration register index
  localparam logic REG_DEDUPE_ENABLE = 1'b0;

  typedef struct packed {
    logic        action;
    logic [7:0]  name_byte;
    logic [63:0] vector_word;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] record_hash;
    logic [1:0]  status;
  } out_item_t;

  // Fold unit -> control
  typedef struct packed {
    logic [63:0] final_hash;
    logic        bad;
  } fold_status_t;

  // Table unit -> control
  typedef struct packed {
    logic done;
    logic hit;
  } tbl_resp_t;

  // x * 0x100000001b3 mod 2^64, as shifts and adds
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [63:0] op);
    fnv_fold = fnv_mul(h ^ op);
  endfunction

endpackage

@@ rtl/core/rhdf_fold.sv @@
// Hash folding unit: operand stage, then the FNV-1a fold of the running hash.
// Depends on rhdf_pkg.
`timescale 1ns / 1ps

module rhdf_fold #(
  parameter int MAX_ELEMENTS = rhdf_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   beat,
  input  rhdf_pkg::in_item_t     item,
  input  logic                   clear,
  output rhdf_pkg::fold_status_t fstat
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

  logic [63:0]      running_hash;
  logic [CNT_W-1:0] element_count;
  logic [63:0]      index_offset;
  logic             record_error;
  logic             op_valid;
  logic [63:0]      operand;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      running_hash  <= rhdf_pkg::FNV_BASIS;
      element_count <= '0;
      index_offset  <= '0;
      record_error  <= 1'b0;
      op_valid      <= 1'b0;
    end else begin
      op_valid <= 1'b0;
      if (op_valid) begin
        running_hash <= rhdf_pkg::fnv_fold(running_hash, operand);
      end
      if (beat) begin
        if (item.action == rhdf_pkg::ACT_NAME) begin
          // names come before any vector word; NUL bytes are skipped
          if (element_count != '0) begin
            record_error <= 1'b1;
          end else if (item.name_byte != 8'd0) begin
            op_valid <= 1'b1;
            operand  <= {56'd0, item.name_byte};
          end
        end else begin
          if (element_count >= CNT_MAX) begin
            record_error <= 1'b1;
          end else begin
            op_valid      <= 1'b1;
            operand       <= item.vector_word + index_offset;
            index_offset  <= index_offset + rhdf_pkg::GOLDEN_STEP;
            element_count <= element_count + CNT_W'(1);
          end
        end
      end
    end
  end

  assign fstat.final_hash = (running_hash == 64'd0) ? 64'd1 : running_hash;
  assign fstat.bad        = record_error | (element_count == '0);

endmodule

@@ rtl/core/rhdf_table.sv @@
// Recent-hash table: one synchronous memory, a linear lookup scan and FIFO insert.
// Depends on rhdf_pkg.
`timescale 1ns / 1ps

module rhdf_table #(
  parameter int TABLE_DEPTH = rhdf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         key,
  output rhdf_pkg::tbl_resp_t resp
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(TABLE_DEPTH);

  logic [63:0] mem [TABLE_DEPTH];

  // entries below fill are the written ones (FIFO order)
  logic [FILL_W-1:0] fill;
  logic [ADDR_W-1:0] wptr;
  logic [ADDR_W-1:0] raddr;
  logic              busy;
  logic              issuing;
  logic              cmp_valid;
  logic              cmp_last;
  logic [63:0]       rdata;
  logic              done;
  logic              hit;
  logic              rd_en;
  logic              match;
  logic              insert;

  assign rd_en  = busy & issuing;
  assign match  = cmp_valid & (rdata == key);
  assign insert = (start & (fill == '0)) | (busy & cmp_valid & ~match & cmp_last);

  always_ff @(posedge clk) begin
    if (insert) begin
      mem[wptr] <= key;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      wptr      <= '0;
      busy      <= 1'b0;
      issuing   <= 1'b0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
      hit       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        hit <= 1'b0;
        if (fill == '0) begin
          done <= 1'b1;
        end else begin
          busy    <= 1'b1;
          issuing <= 1'b1;
          raddr   <= '0;
        end
      end else if (busy) begin
        if (issuing) begin
          cmp_valid <= 1'b1;
          cmp_last  <= (FILL_W'(raddr) == fill - FILL_W'(1));
          raddr     <= raddr + ADDR_W'(1);
          if (FILL_W'(raddr) == fill - FILL_W'(1)) begin
            issuing <= 1'b0;
          end
        end else begin
          cmp_valid <= 1'b0;
        end
        if (match) begin
          done      <= 1'b1;
          hit       <= 1'b1;
          busy      <= 1'b0;
          issuing   <= 1'b0;
          cmp_valid <= 1'b0;
        end else if (cmp_valid && cmp_last) begin
          done      <= 1'b1;
          busy      <= 1'b0;
          cmp_valid <= 1'b0;
        end
      end
      if (insert) begin
        wptr <= (wptr == LAST_ADDR) ? '0 : wptr + ADDR_W'(1);
        if (fill != FULL) begin
          fill <= fill + FILL_W'(1);
        end
      end
    end
  end

  assign resp.done = done;
  assign resp.hit  = hit;

endmodule

@@ rtl/core/record_hash_dedup_filter.sv @@
// Top level of the record hash dedup filter: handshakes, APB register, control.
// Depends on rhdf_pkg, rhdf_fold and rhdf_table.
//
//  channel  | signals                                   | beat
//  ---------+-------------------------------------------+---------------------------
//  in       | in_valid, in_ready, in_data (in_item_t)   | one name byte or one word
//  out      | out_valid, out_ready, out_data (out_item_t)| one result per record
//  apb      | psel, penable, pwrite, paddr, pwdata,     | dedupe_enable at 0x0
//           | prdata, pready                            |
//
// Flow: name and vector beats fold at one per cycle while in_ready is high.
// A last beat leads through the settle and decide states, then (when dedupe
// is on and the record is good) a lookup over the stored hashes, whose
// number is fill (up to TABLE_DEPTH); one memory read port scans one entry
// a cycle. Then the result beat is loaded, later if out_ready stalls it.
// Reset: synchronous; the table starts empty via its fill count, so no
// clearing pass is run. A result waiting in the output register does not
// hold off the next record's beats, only that record's own result.
`timescale 1ns / 1ps

module record_hash_dedup_filter #(
  parameter int TABLE_DEPTH  = rhdf_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_ELEMENTS = rhdf_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rhdf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rhdf_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [2:0] ST_FOLD   = 3'd0;
  localparam logic [2:0] ST_SETTLE = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [1:0]             status;
  logic [1:0]             status_next;
  logic                   dedupe_enable;
  logic                   in_beat;
  logic                   out_load;
  logic                   tbl_start;
  rhdf_pkg::fold_status_t fstat;
  rhdf_pkg::tbl_resp_t    tresp;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dedupe_enable <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == rhdf_pkg::REG_DEDUPE_ENABLE) begin
      dedupe_enable <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == rhdf_pkg::REG_DEDUPE_ENABLE) ? {31'd0, dedupe_enable} : 32'd0;

  // ---------------- datapath units ----------------
  assign in_ready = (state == ST_FOLD);
  assign in_beat  = in_valid & in_ready;

  rhdf_fold #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_fold (
    .clk  (clk),
    .rst  (rst),
    .beat (in_beat),
    .item (in_data),
    .clear(out_load),
    .fstat(fstat)
  );

  rhdf_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .start(tbl_start),
    .key  (fstat.final_hash),
    .resp (tresp)
  );

  // ---------------- record control ----------------
  // Kick off the lookup only for a good record with dedupe on.
  assign tbl_start = (state == ST_DECIDE) & ~fstat.bad & dedupe_enable;
  // Load the result once the output register is free or draining.
  assign out_load  = (state == ST_EMIT) & (~out_valid | out_ready);

  always_comb begin
    state_next  = state;
    status_next = status;
    case (state)
      ST_FOLD: begin
        if (in_beat && in_data.last) begin
          state_next = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        // last operand folds into the running hash this cycle
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (fstat.bad) begin
          status_next = rhdf_pkg::STATUS_REJECT;
          state_next  = ST_EMIT;
        end else if (!dedupe_enable) begin
          status_next = rhdf_pkg::STATUS_DISABLED;
          state_next  = ST_EMIT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tresp.done) begin
          status_next = tresp.hit ? rhdf_pkg::STATUS_DUP : rhdf_pkg::STATUS_NEW;
          state_next  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_next = ST_FOLD;
        end
      end
      default: begin
        state_next = ST_FOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FOLD;
    end else begin
      state <= state_next;
    end
    status <= status_next;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data.record_hash <= fstat.final_hash;
      out_data.status      <= status;
    end
  end

endmodule

@@ rtl/core/rhdf_checker.sv @@
// Port-level checker for record_hash_dedup_filter, attached by bind.
// Depends on rhdf_pkg.
`timescale 1ns / 1ps

module rhdf_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input rhdf_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input rhdf_pkg::out_item_t out_data
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed or dropped");

  // a result hash is never zero
  a_hash_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.record_hash != 64'd0)
    else $error("result hash is zero");

  // a record's last beat closes input, so in_ready drops after it
  a_last_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last |=> !in_ready)
    else $error("input still open after last beat");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind record_hash_dedup_filter rhdf_checker u_rhdf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

@@ dv/tb.sv @@
// Self-checking testbench for record_hash_dedup_filter: stimulus queue, driver,
// monitor, APB register writes and a cycle-free predictor of the hash and table.
// Depends on rhdf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb;

  // The block runs at its default table depth and record length.
  localparam int TBL_DEPTH = rhdf_pkg::TABLE_DEPTH_DEF;
  localparam int MAX_ELEMS = rhdf_pkg::MAX_ELEMENTS_DEF;
  localparam int LONG_WORDS = 16;      // upper end of a longer random record

  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam int STALL_LIMIT = 4000;   // cycles with no beat anywhere
  localparam int SETTLE_CYC = 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  rhdf_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  rhdf_pkg::out_item_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  record_hash_dedup_filter #(
    .TABLE_DEPTH (TBL_DEPTH),
    .MAX_ELEMENTS(MAX_ELEMS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ---------------------------------------------------------------------------
  // Stimulus store and shadow state
  // ---------------------------------------------------------------------------
  rhdf_pkg::in_item_t  beat_q[$];       // beats waiting for the driver
  rhdf_pkg::in_item_t  rec_buf[$];      // beats of the record being built
  rhdf_pkg::in_item_t  lib_beats[$];    // well-formed records kept for replay
  int                  lib_start[$];
  int                  lib_len[$];
  int                  beats_queued = 0;
  rhdf_pkg::out_item_t due_results[$];  // predicted results, oldest first
  rhdf_pkg::out_item_t want_res;

  bit        idle_on = 1'b1;
  int        in_gap = 0;
  int        out_gap = 0;
  int        err_cnt = 0;
  int        quiet_cyc = 0;

  // Predictor state: per-record fold plus the recent-hash FIFO
  logic [63:0] acc_hash = rhdf_pkg::FNV_BASIS;
  int          word_cnt = 0;
  logic [63:0] idx_off = '0;
  bit          rec_bad = 1'b0;
  bit [63:0]   seen_hash[TBL_DEPTH];
  bit          seen_valid[TBL_DEPTH];
  int          seen_wp = 0;
  bit          dedupe_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_error(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: fold one accepted beat, emit the record's result on last
  // ---------------------------------------------------------------------------
  task automatic absorb_beat(rhdf_pkg::in_item_t b);
    logic [63:0]         fin;
    rhdf_pkg::out_item_t res;
    bit                  hit;
    hit = 1'b0;
    if (b.action == rhdf_pkg::ACT_NAME) begin
      // a name byte after any word spoils the record; NUL bytes are skipped
      if (word_cnt > 0) begin
        rec_bad = 1'b1;
      end else if (b.name_byte != 8'd0) begin
        acc_hash = (acc_hash ^ {56'd0, b.name_byte}) * FNV_PRIME;
      end
    end else begin
      // words past the limit spoil the record and are not folded
      if (word_cnt >= MAX_ELEMS) begin
        rec_bad = 1'b1;
      end else begin
        acc_hash = (acc_hash ^ (b.vector_word + idx_off)) * FNV_PRIME;
        idx_off  = idx_off + rhdf_pkg::GOLDEN_STEP;
        word_cnt++;
      end
    end
    if (b.last) begin
      fin = (acc_hash == 64'd0) ? 64'd1 : acc_hash;
      res.record_hash = fin;
      if (rec_bad || word_cnt == 0) begin
        res.status = rhdf_pkg::STATUS_REJECT;
      end else if (!dedupe_on) begin
        res.status = rhdf_pkg::STATUS_DISABLED;
      end else begin
        for (int i = 0; i < TBL_DEPTH; i++) begin
          if (seen_valid[i] && seen_hash[i] == fin) hit = 1'b1;
        end
        if (hit) begin
          res.status = rhdf_pkg::STATUS_DUP;
        end else begin
          seen_hash[seen_wp]  = fin;
          seen_valid[seen_wp] = 1'b1;
          seen_wp = (seen_wp + 1) % TBL_DEPTH;
          res.status = rhdf_pkg::STATUS_NEW;
        end
      end
      due_results.push_back(res);
      acc_hash = rhdf_pkg::FNV_BASIS;
      word_cnt = 0;
      idx_off  = '0;
      rec_bad  = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0:       rand_word = 64'd0;
      1:       rand_word = '1;
      2:       rand_word = 64'd1 << $urandom_range(0, 63);
      default: rand_word = {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] rand_name();
    rand_name = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  function automatic int rand_words();
    rand_words = ($urandom_range(0, 7) == 0) ? $urandom_range(4, LONG_WORDS)
                                             : $urandom_range(1, 3);
  endfunction

  // Queue one beat; the field the beat does not use gets random content.
  task automatic add_beat(logic act, logic [7:0] nb, logic [63:0] vw, logic lst);
    rhdf_pkg::in_item_t b;
    b.action      = act;
    b.name_byte   = (act == rhdf_pkg::ACT_VECTOR) ? 8'($urandom) : nb;
    b.vector_word = (act == rhdf_pkg::ACT_NAME) ? rand_word() : vw;
    b.last        = lst;
    beat_q.push_back(b);
    rec_buf.push_back(b);
    beats_queued++;
  endtask

  task automatic close_record(bit keep);
    if (keep) begin
      lib_start.push_back(lib_beats.size());
      lib_len.push_back(rec_buf.size());
      foreach (rec_buf[i]) lib_beats.push_back(rec_buf[i]);
    end
    rec_buf.delete();
  endtask

  task automatic make_good(int names, int words);
    for (int i = 0; i < names; i++) add_beat(rhdf_pkg::ACT_NAME, rand_name(), '0, 1'b0);
    for (int i = 0; i < words; i++)
      add_beat(rhdf_pkg::ACT_VECTOR, '0, rand_word(), i == words - 1);
    close_record(1'b1);
  endtask

  // Misordered or empty record
  task automatic make_broken();
    int nm, wd, tl;
    case ($urandom_range(0, 1))
      0: begin
        nm = $urandom_range(0, 2);
        wd = $urandom_range(1, 3);
        tl = $urandom_range(0, 2);
        for (int i = 0; i < nm; i++) add_beat(rhdf_pkg::ACT_NAME, rand_name(), '0, 1'b0);
        for (int i = 0; i < wd; i++) add_beat(rhdf_pkg::ACT_VECTOR, '0, rand_word(), 1'b0);
        add_beat(rhdf_pkg::ACT_NAME, rand_name(), '0, tl == 0);
        for (int i = 0; i < tl; i++)
          add_beat(rhdf_pkg::ACT_VECTOR, '0, rand_word(), i == tl - 1);
      end
      default: begin
        nm = $urandom_range(1, 3);
        for (int i = 0; i < nm; i++)
          add_beat(rhdf_pkg::ACT_NAME, rand_name(), '0, i == nm - 1);
      end
    endcase
    close_record(1'b0);
  endtask

  task automatic replay_at(int k);
    for (int i = 0; i < lib_len[k]; i++) begin
      beat_q.push_back(lib_beats[lib_start[k] + i]);
      beats_queued++;
    end
  endtask

  // Replay one of the recent good records; it hits in the table if it was stored.
  task automatic replay_recent();
    int span;
    span = (lib_start.size() > 24) ? 24 : lib_start.size();
    replay_at(lib_start.size() - 1 - $urandom_range(0, span - 1));
  endtask

  task automatic random_records(int target);
    int stop, pick;
    stop = beats_queued + target;
    while (beats_queued < stop) begin
      pick = $urandom_range(0, 9);
      if (pick >= 8) make_broken();
      else if (pick >= 6 && lib_start.size() > 0) replay_recent();
      else make_good($urandom_range(0, 4), rand_words());
    end
  endtask

  // Hold until every queued beat is accepted and every result has come back,
  // then let the block idle before touching the register.
  task automatic drain();
    while (beat_q.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // APB write of dedupe_enable, then read it back
  task automatic set_dedupe(bit v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(rhdf_pkg::REG_DEDUPE_ENABLE));
    pwdata  <= {31'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    dedupe_on = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[0] !== v) flag_error($sformatf("dedupe_enable reads %b, wrote %b", prdata[0], v));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued beats, fold each accepted beat into the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) absorb_beat(in_data);
      // slot is free when nothing is shown or the shown beat just went in
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (beat_q.size() > 0) begin
          in_data  <= beat_q.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall the result channel in bursts, compare each result beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          flag_error($sformatf("unexpected result hash %h status %0d",
                               out_data.record_hash, out_data.status));
        end else begin
          want_res = due_results.pop_front();
          if (out_data.record_hash !== want_res.record_hash)
            flag_error($sformatf("record_hash %h, want %h",
                                 out_data.record_hash, want_res.record_hash));
          if (out_data.status !== want_res.status)
            flag_error($sformatf("status %0d, want %0d (hash %h)",
                                 out_data.status, want_res.status, want_res.record_hash));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 5);
      end
    end
  end

  // Watchdog: abort when no beat moves on any port for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cyc = 0;
    end else begin
      quiet_cyc++;
      if (quiet_cyc >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, dedupe on from reset: names at both byte extremes plus a NUL,
    // words at both extremes
    add_beat(rhdf_pkg::ACT_NAME, 8'hff, '0, 1'b0);
    add_beat(rhdf_pkg::ACT_NAME, 8'h01, '0, 1'b0);
    add_beat(rhdf_pkg::ACT_NAME, 8'h00, '0, 1'b0);
    add_beat(rhdf_pkg::ACT_VECTOR, '0, 64'd0, 1'b0);
    add_beat(rhdf_pkg::ACT_VECTOR, '0, '1, 1'b1);
    close_record(1'b1);
    replay_at(0);                                    // same record again: duplicate
    add_beat(rhdf_pkg::ACT_VECTOR, '0, rhdf_pkg::FNV_BASIS, 1'b1); // folds to zero
    close_record(1'b1);
    add_beat(rhdf_pkg::ACT_NAME, 8'h41, '0, 1'b1);   // no words: empty record
    add_beat(rhdf_pkg::ACT_NAME, 8'h00, '0, 1'b1);   // empty, nothing folded at all
    add_beat(rhdf_pkg::ACT_VECTOR, '0, rhdf_pkg::FNV_BASIS, 1'b0); // name after word
    add_beat(rhdf_pkg::ACT_NAME, 8'h07, '0, 1'b1);
    for (int i = 0; i <= MAX_ELEMS; i++)             // one word too many
      add_beat(rhdf_pkg::ACT_VECTOR, '0, rand_word(), i == MAX_ELEMS);
    close_record(1'b0);
    drain();

    // Dedupe off: known record passes, an empty one is still rejected
    set_dedupe(1'b0);
    replay_at(0);
    add_beat(rhdf_pkg::ACT_NAME, 8'h80, '0, 1'b1);
    close_record(1'b0);
    drain();

    set_dedupe(1'b1);
    random_records(250);
    drain();

    set_dedupe(1'b0);
    random_records(100);
    drain();

    set_dedupe(1'b1);
    random_records(150);
    drain();

    // Last stretch at full rate on both sides
    idle_on = 1'b0;
    random_records(120);
    while (beat_q.size() != 0 || in_valid || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC * 2) @(negedge clk);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
